// ----- hdl/fpn_pkg.sv -----
// Package with the constants, permutation table and helpers of the fractal noise block.
package fpn_pkg;

  localparam int unsigned MaxOctaves = 8;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned FracW      = FracBits;
  localparam int unsigned WeightW    = FracBits + 1;
  localparam int unsigned ValW       = FracBits + 4;
  localparam int unsigned MulAW      = FracBits + 8;
  localparam int unsigned MulBW      = FracBits + 2;
  localparam int unsigned ProdW      = MulAW + MulBW;
  localparam int unsigned SumW       = 40;
  localparam int unsigned OctW       = 4;
  localparam int unsigned PersW      = 17;

  localparam logic [PersW-1:0] OneQ16 = PersW'(65536);

  localparam logic [1:0] CfgDimMode  = 2'd0;
  localparam logic [1:0] CfgOctaves  = 2'd1;
  localparam logic [1:0] CfgPersist  = 2'd2;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic signed [ValW-1:0] grad_fn(
      input logic [1:0] dims, input logic [7:0] h,
      input logic signed [ValW-1:0] dx, input logic signed [ValW-1:0] dy,
      input logic signed [ValW-1:0] dz);
    logic [3:0] h4;
    logic signed [ValW-1:0] u;
    logic signed [ValW-1:0] v;
    h4 = h[3:0];
    if (dims == 2'd1) begin
      u = dx;
      v = '0;
    end else if (dims == 2'd2) begin
      u = dx;
      v = dy;
    end else begin
      u = (h4 < 4'd8) ? dx : dy;
      v = (h4 < 4'd4) ? dy : ((h4 == 4'd12 || h4 == 4'd14) ? dx : dz);
    end
    grad_fn = (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

endpackage

// ----- hdl/fractal_perlin_noise.sv -----
// Fractal Brownian motion of improved Perlin noise on one shared multiplier.
// A word whose dimension mode sums no octave goes straight to its result word; else each octave
// runs through the setup, fade, hash, lerp, accumulate and amplitude steps in that order, paced
// by the one shared multiplier and by one permutation lookup per cycle in the hash step.
// One word is worked on at a time; the next is taken in the cycle after the result word has left.
// Reset is asynchronous and active low; it loads 3 dimensions, 1 octave and persistence 0.5.
module fractal_perlin_noise import fpn_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] coord_x_i,
  input  logic signed [CoordW-1:0] coord_y_i,
  input  logic signed [CoordW-1:0] coord_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [31:0]       noise_value_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [PersW-1:0]         cfg_data_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSetup = 3'd1;
  localparam logic [2:0] StFade  = 3'd2;
  localparam logic [2:0] StHash  = 3'd3;
  localparam logic [2:0] StLerp  = 3'd4;
  localparam logic [2:0] StAcc   = 3'd5;
  localparam logic [2:0] StAmp   = 3'd6;
  localparam logic [2:0] StDone  = 3'd7;

  localparam logic signed [MulAW-1:0] FifteenOne = MulAW'(15 * (1 << FracBits));
  localparam logic signed [MulAW-1:0] TenOne     = MulAW'(10 * (1 << FracBits));
  localparam logic signed [ValW-1:0]  OneVal     = ValW'(1 << FracBits);

  logic [1:0]        cfg_dims_q;
  logic [3:0]        cfg_oct_q;
  logic [PersW-1:0]  cfg_pers_q;

  logic [2:0]        state_q;
  logic              phase_q;
  logic [1:0]        dims_q;
  logic [OctW-1:0]   n_q;
  logic [OctW-1:0]   oct_q;
  logic [PersW-1:0]  pers_q;
  logic [CoordW-1:0] crd_q [3];
  logic [7:0]        lat_q [3];
  logic [FracW-1:0]  fr_q [3];
  logic [WeightW-1:0] sw_q [3];
  logic [1:0]        k_q;
  logic [1:0]        sub_q;
  logic signed [MulAW-1:0] ta_q;
  logic signed [MulAW-1:0] tp_q;
  logic [2:0]        corner_q;
  logic [1:0]        lvl_q;
  logic [7:0]        h_q;
  logic signed [ValW-1:0] q_q [8];
  logic [3:0]        cnt_q;
  logic [2:0]        lj_q;
  logic signed [SumW-1:0]  sum_q;
  logic [PersW-1:0]  amp_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [31:0] out_q;

  logic [OctW-1:0]   n_eff;
  logic [PersW-1:0]  pers_eff;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-FracBits-1:0] mres;
  logic [FracW-1:0]  t_cur;
  logic [7:0]        hash_addr;
  logic [7:0]        hash_val;
  logic signed [ValW-1:0] gdx, gdy, gdz, gval;
  logic [WeightW-1:0] lw;
  logic signed [ValW-1:0] lres;
  logic signed [MulAW-1:0] wclamp;
  logic [2:0]        lerp_total;
  logic signed [31:0] sat_sum;
  logic              in_acc;

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StDone);
  assign noise_value_o = out_q;

  assign n_eff = (cfg_dims_q == 2'd0) ? '0 :
                 ((cfg_oct_q > OctW'(MaxOctaves)) ? OctW'(MaxOctaves) : cfg_oct_q);
  assign pers_eff = (cfg_pers_q > OneQ16) ? OneQ16 : cfg_pers_q;
  assign t_cur = fr_q[k_q];
  assign mres = prod_q[ProdW-1:FracBits];
  assign lerp_total = 3'((1 << dims_q) - 1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StFade: begin
        case (sub_q)
          2'd0: begin
            mul_a = MulAW'({1'b0, t_cur});
            mul_b = MulBW'({1'b0, t_cur});
          end
          2'd1: begin
            mul_a = ta_q;
            mul_b = MulBW'({1'b0, t_cur});
          end
          2'd2: begin
            mul_a = MulAW'({1'b0, t_cur, 2'b0}) + MulAW'({1'b0, t_cur, 1'b0}) - FifteenOne;
            mul_b = MulBW'({1'b0, t_cur});
          end
          default: begin
            mul_a = tp_q;
            mul_b = ta_q[MulBW-1:0];
          end
        endcase
      end
      StLerp: begin
        mul_a = MulAW'(q_q[1]) - MulAW'(q_q[0]);
        mul_b = MulBW'({1'b0, lw});
      end
      StAcc: begin
        mul_a = MulAW'(q_q[0]);
        mul_b = MulBW'({1'b0, amp_q});
      end
      StAmp: begin
        mul_a = MulAW'({1'b0, pers_q});
        mul_b = MulBW'({1'b0, amp_q});
      end
      default: ;
    endcase
  end

  always_comb begin
    if (dims_q == 2'd1) begin
      lw = sw_q[0];
    end else if (dims_q == 2'd2) begin
      lw = (lj_q < 3'd2) ? sw_q[0] : sw_q[1];
    end else begin
      lw = (lj_q < 3'd4) ? sw_q[0] : ((lj_q < 3'd6) ? sw_q[1] : sw_q[2]);
    end
  end

  always_comb begin
    if (lvl_q == 2'd0) begin
      hash_addr = lat_q[0] + 8'(corner_q[0]);
    end else begin
      hash_addr = h_q + lat_q[lvl_q] + 8'(corner_q[lvl_q]);
    end
    hash_val = PERM[hash_addr];
    gdx = ValW'({1'b0, fr_q[0]}) - (corner_q[0] ? OneVal : '0);
    gdy = ValW'({1'b0, fr_q[1]}) - (corner_q[1] ? OneVal : '0);
    gdz = ValW'({1'b0, fr_q[2]}) - (corner_q[2] ? OneVal : '0);
    gval = grad_fn(dims_q, hash_val, gdx, gdy, gdz);
  end

  assign lres = q_q[0] + ValW'(mres);

  always_comb begin
    wclamp = MulAW'(mres);
    if (mres < 0) begin
      wclamp = '0;
    end else if (mres > (ProdW-FracBits)'(1 << FracBits)) begin
      wclamp = MulAW'(1 << FracBits);
    end
  end

  always_comb begin
    if (sum_q > SumW'(32'sh7fffffff)) begin
      sat_sum = 32'sh7fffffff;
    end else if (sum_q < -SumW'(33'sh080000000)) begin
      sat_sum = 32'sh80000000;
    end else begin
      sat_sum = sum_q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dims_q <= 2'd3;
      cfg_oct_q  <= 4'd1;
      cfg_pers_q <= PersW'(32768);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDimMode: cfg_dims_q <= cfg_data_i[1:0];
        CfgOctaves: cfg_oct_q  <= cfg_data_i[3:0];
        CfgPersist: cfg_pers_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      phase_q  <= 1'b0;
      k_q      <= '0;
      sub_q    <= '0;
      corner_q <= '0;
      lvl_q    <= '0;
      cnt_q    <= '0;
      lj_q     <= '0;
      oct_q    <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            oct_q   <= '0;
            phase_q <= 1'b0;
            state_q <= (n_eff == '0) ? StDone : StSetup;
          end
        end
        StSetup: begin
          k_q     <= '0;
          sub_q   <= '0;
          phase_q <= 1'b0;
          state_q <= StFade;
        end
        StFade: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            sub_q <= sub_q + 2'd1;
            if (sub_q == 2'd3) begin
              k_q <= k_q + 2'd1;
              if (k_q + 2'd1 == dims_q) begin
                corner_q <= '0;
                lvl_q    <= '0;
                cnt_q    <= '0;
                state_q  <= StHash;
              end
            end
          end
        end
        StHash: begin
          if (lvl_q + 2'd1 == dims_q) begin
            lvl_q    <= '0;
            corner_q <= corner_q + 3'd1;
            cnt_q    <= cnt_q + 4'd1;
            if (corner_q == lerp_total) begin
              lj_q    <= '0;
              phase_q <= 1'b0;
              state_q <= StLerp;
            end
          end else begin
            lvl_q <= lvl_q + 2'd1;
          end
        end
        StLerp: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            cnt_q <= cnt_q - 4'd1;
            lj_q  <= lj_q + 3'd1;
            if (cnt_q == 4'd2) begin
              state_q <= StAcc;
            end
          end
        end
        StAcc: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            state_q <= StAmp;
          end
        end
        StAmp: begin
          phase_q <= !phase_q;
          if (phase_q) begin
            oct_q   <= oct_q + 1'b1;
            state_q <= (oct_q + 1'b1 == n_q) ? StDone : StSetup;
          end
        end
        StDone: begin
          if (!out_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (!phase_q) begin
      prod_q <= mul_a * mul_b;
    end
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          dims_q <= cfg_dims_q;
          n_q    <= n_eff;
          pers_q <= pers_eff;
          crd_q[0] <= coord_x_i;
          crd_q[1] <= coord_y_i;
          crd_q[2] <= coord_z_i;
          amp_q  <= OneQ16;
          sum_q  <= '0;
          out_q  <= '0;
        end
      end
      StSetup: begin
        for (int i = 0; i < 3; i++) begin
          if (i < int'(dims_q)) begin
            lat_q[i] <= 8'((crd_q[i] << oct_q[2:0]) >> FracBits);
            fr_q[i]  <= FracW'(crd_q[i] << oct_q[2:0]);
          end else begin
            lat_q[i] <= '0;
            fr_q[i]  <= '0;
          end
        end
      end
      StFade: begin
        if (phase_q) begin
          case (sub_q)
            2'd0, 2'd1: ta_q <= MulAW'(mres);
            2'd2: tp_q <= MulAW'(mres) + TenOne;
            default: sw_q[k_q] <= WeightW'(wclamp);
          endcase
        end
      end
      StHash: begin
        h_q <= hash_val;
        if (lvl_q + 2'd1 == dims_q) begin
          q_q[cnt_q[2:0]] <= gval;
        end
      end
      StLerp: begin
        if (phase_q) begin
          for (int i = 0; i < 6; i++) begin
            q_q[i] <= q_q[i+2];
          end
          q_q[3'(cnt_q - 4'd2)] <= lres;
        end
      end
      StAcc: begin
        if (phase_q) begin
          sum_q <= sum_q + SumW'(mres);
        end
      end
      StAmp: begin
        if (phase_q) begin
          amp_q <= PersW'(mres);
          out_q <= sat_sum;
        end
      end
      default: ;
    endcase
  end

  a_amp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle && state_q != StDone) |-> (amp_q <= OneQ16))
    else $error("amplitude exceeds one");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= 4'd8))
    else $error("corner queue overflow");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block ready right after accepting a word");

  a_octave_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSetup) |-> (oct_q < n_q))
    else $error("octave index past octave count");

endmodule
